>>> rtl/csbm_pkg.sv
// Package for the concatenated / striped block mapper.
// Holds shared widths, register and status codes, payload types and FSM enums.
// No dependencies.
`default_nettype none
package csbm_pkg;

  localparam int COMPONENTS         = 4;
  localparam int NREG               = COMPONENTS + 1;
  localparam int BLOCK_BYTES        = 512;
  localparam int BLOCK_SHIFT        = 9;
  localparam int MAX_REQUEST_BLOCKS = 64;
  localparam int MAX_REQ_BYTES      = MAX_REQUEST_BLOCKS * BLOCK_BYTES;

  localparam int LBA_W    = 34;
  localparam int SIZE_W   = 32;
  localparam int IL_W     = 16;
  localparam int BYTES_W  = 16;
  localparam int CFG_W    = 32;
  localparam int CIDX_W   = 3;
  localparam int DCNT_W   = 6;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_INTERLEAVE = 3'd0;
  localparam logic [CIDX_W-1:0] REG_UNIFORM    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_COUNT      = 3'd2;
  localparam logic [CIDX_W-1:0] REG_SIZE0      = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SIZE1      = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SIZE2      = 3'd5;
  localparam logic [CIDX_W-1:0] REG_SIZE3      = 3'd6;

  // result status codes
  localparam logic [1:0] STAT_PIECE    = 2'd0;
  localparam logic [1:0] STAT_AT_END   = 2'd1;
  localparam logic [1:0] STAT_INVALID  = 2'd2;
  localparam logic [1:0] STAT_UNCONFIG = 2'd3;

  typedef struct packed {
    logic [LBA_W-1:0]   start_block;
    logic [BYTES_W-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         disk_index;
    logic [SIZE_W-1:0]  disk_block;
    logic [BYTES_W-1:0] piece_bytes;
    logic               last;
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_RB_INIT, OP_TRUNC_DIV, OP_TRUNC_STORE, OP_UNIFORM, OP_SUM,
    OP_SER_REGION, OP_FIND, OP_DIV_BN, OP_STORE_START, OP_STORE_REGION,
    OP_RB_DONE, OP_LOAD, OP_CHECK, OP_DIV_UNIT, OP_SEL, OP_OFF, OP_DIV_ND,
    OP_CB, OP_MUL, OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_RB_INIT, ST_TRUNC, ST_TRUNC_WAIT, ST_TRUNC_STORE, ST_UNIFORM, ST_SUM,
    ST_SER_REGION, ST_FIND, ST_FIND_CHK, ST_WAIT_BN, ST_WAIT_PREV, ST_RB_DONE,
    ST_IDLE, ST_CHECK, ST_DIV_UNIT, ST_WAIT_UNIT, ST_SEL, ST_OFF, ST_DIV_ND,
    ST_WAIT_ND, ST_CB, ST_MUL, ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic n_zero;
    logic i_eq_n;
    logic i_eq_last;
    logic trunc_zero;
    logic il_zero;
    logic div_done;
    logic r_full;
    logic found;
    logic chk_stop;
    logic nd_le1;
    logic emit_last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/csbm_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on csbm_pkg for widths.
`default_nettype none
module csbm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [csbm_pkg::LBA_W-1:0]   dividend_i,
  input  logic [csbm_pkg::IL_W-1:0]    divisor_i,
  output logic [csbm_pkg::LBA_W-1:0]   quo_o,
  output logic [csbm_pkg::IL_W-1:0]    rem_o,
  output logic                         done_o
);

  logic [csbm_pkg::DCNT_W-1:0] cnt_q;
  logic                        done_q;
  logic [csbm_pkg::LBA_W-1:0]  quo_q;
  logic [csbm_pkg::IL_W-1:0]   rem_q;
  logic [csbm_pkg::IL_W-1:0]   dvs_q;
  logic [csbm_pkg::IL_W:0]     trial;
  logic                        ge;
  logic [csbm_pkg::IL_W:0]     diff;

  assign trial = {rem_q, quo_q[csbm_pkg::LBA_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= csbm_pkg::DCNT_W'(csbm_pkg::LBA_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == csbm_pkg::DCNT_W'(1)) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[csbm_pkg::LBA_W-2:0], ge};
      rem_q <= ge ? diff[csbm_pkg::IL_W-1:0] : trial[csbm_pkg::IL_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

>>> rtl/csbm_dp.sv
// Datapath: configuration registers, stripe table, request registers and result register.
// Depends on csbm_pkg and csbm_div.
`default_nettype none
module csbm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [csbm_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [csbm_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          cfg_ready_o,
  input  csbm_pkg::req_t                req_i,
  input  csbm_pkg::dp_cmd_t             cmd_i,
  output csbm_pkg::dp_stat_t            stat_o,
  output csbm_pkg::res_t                res_o,
  output logic                          res_strobe_o
);

  localparam int NR = csbm_pkg::NREG;
  localparam int NC = csbm_pkg::COMPONENTS;
  localparam int LW = csbm_pkg::LBA_W;
  localparam int SW = csbm_pkg::SIZE_W;
  localparam int BW = csbm_pkg::BYTES_W;
  localparam int IW = csbm_pkg::IL_W;
  localparam int SH = csbm_pkg::BLOCK_SHIFT;

  // configuration
  logic [IW-1:0] il_q;
  logic          uni_q;
  logic [2:0]    cnt_q;
  logic [SW-1:0] raw_q [NC];

  // stripe table and rebuild state
  logic [SW-1:0] used_q [NC];
  logic [LW-1:0] total_q;
  logic          cfg_ok_q;
  logic [LW-1:0] rs_q [NR];
  logic [SW-1:0] ro_q [NR];
  logic [2:0]    rc_q [NR];
  logic [7:0]    rm_q [NR];
  logic [2:0]    i_q, r_q, n_q, fcnt_q;
  logic [SW-1:0] min_q, prev_q, small_q;
  logic [7:0]    fmem_q;
  logic          fail_q, found_q;
  logic [LW-1:0] acc_q;

  // request state
  logic [LW-1:0] bn_q, unit_q, off_q, cb_q;
  logic [BW-1:0] bytes_q;
  logic [IW-1:0] cboff_q;
  logic [2:0]    sel_q;
  logic [1:0]    disk_q;
  logic [SW-1:0] blk_q;
  csbm_pkg::res_t res_q;
  logic           strobe_q;

  // divider
  logic          div_start;
  logic [LW-1:0] div_dividend, div_quo;
  logic [IW-1:0] div_divisor, div_rem;
  logic          div_done;

  csbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = il_q;
    case (cmd_i.op)
      csbm_pkg::OP_TRUNC_DIV: begin
        div_start    = 1'b1;
        div_dividend = {2'b00, raw_q[i_q[1:0]]};
      end
      csbm_pkg::OP_DIV_BN: begin
        div_start    = 1'b1;
        div_dividend = acc_q;
      end
      csbm_pkg::OP_STORE_START: begin
        div_start    = 1'b1;
        div_dividend = {2'b00, prev_q};
      end
      csbm_pkg::OP_DIV_UNIT: begin
        div_start    = 1'b1;
        div_dividend = bn_q;
      end
      csbm_pkg::OP_DIV_ND: begin
        div_start    = 1'b1;
        div_dividend = off_q;
        div_divisor  = {{(IW-3){1'b0}}, rc_q[sel_q]};
      end
      default: ;
    endcase
  end

  // rebuild helpers
  logic [2:0]    n_sat;
  logic          il_zero, il_gt1;
  logic [SW-1:0] trunc_s;
  logic [SW-1:0] small_c;
  logic          found_c;
  logic [2:0]    fcnt_c;
  logic [7:0]    fmem_c;
  logic [SW-1:0] step_d;
  logic [LW-1:0] step_scaled;

  assign n_sat   = (cnt_q > 3'(NC)) ? 3'(NC) : cnt_q;
  assign il_zero = (il_q == '0);
  assign il_gt1  = (il_q > IW'(1));
  assign trunc_s = il_gt1 ? raw_q[i_q[1:0]] - {{(SW-IW){1'b0}}, div_rem}
                          : raw_q[i_q[1:0]];

  always_comb begin
    small_c = '0;
    found_c = 1'b0;
    fcnt_c  = '0;
    fmem_c  = '0;
    for (int k = 0; k < NC; k++) begin
      if ((3'(k) < n_q) && (used_q[k] > prev_q) && (!found_c || used_q[k] < small_c)) begin
        small_c = used_q[k];
        found_c = 1'b1;
      end
    end
    for (int k = 0; k < NC; k++) begin
      if ((3'(k) < n_q) && (used_q[k] >= small_c)) begin
        fmem_c = fmem_c | (8'(k) << {fcnt_c[1:0], 1'b0});
        fcnt_c = fcnt_c + 3'd1;
      end
    end
  end

  assign step_d      = small_q - prev_q;
  assign step_scaled = (fcnt_q[0] ? {2'b00, step_d} : '0)
                     + (fcnt_q[1] ? {1'b0, step_d, 1'b0} : '0)
                     + (fcnt_q[2] ? {step_d, 2'b00} : '0);

  // request checks
  logic [BW:0]   sz;
  logic [LW:0]   end_blk;
  logic          oversize, overrun, at_end, trivial, chk_stop;
  logic [1:0]    chk_code;

  assign sz       = ({1'b0, bytes_q} + (BW+1)'(csbm_pkg::BLOCK_BYTES - 1)) >> SH;
  assign oversize = {1'b0, bytes_q} > (BW+1)'(csbm_pkg::MAX_REQ_BYTES);
  assign end_blk  = {1'b0, bn_q} + (LW+1)'(sz);
  assign overrun  = end_blk > {1'b0, total_q};
  assign at_end   = (bn_q == total_q);
  assign trivial  = (bytes_q == '0) || (bn_q >= total_q);

  always_comb begin
    chk_stop = 1'b1;
    chk_code = csbm_pkg::STAT_AT_END;
    if (!cfg_ok_q)     chk_code = csbm_pkg::STAT_UNCONFIG;
    else if (oversize) chk_code = csbm_pkg::STAT_INVALID;
    else if (overrun)  chk_code = at_end ? csbm_pkg::STAT_AT_END : csbm_pkg::STAT_INVALID;
    else if (trivial)  chk_code = csbm_pkg::STAT_AT_END;
    else               chk_stop = 1'b0;
  end

  // region select: last valid region whose start does not exceed the unit
  logic [LW-1:0] unit_c;
  logic [2:0]    sel_c;
  logic          run_ok;

  assign unit_c = il_zero ? bn_q : div_quo;

  always_comb begin
    run_ok = 1'b1;
    sel_c  = '0;
    for (int r = 0; r < NR; r++) begin
      if (rc_q[r] == '0 || rs_q[r] > unit_c) run_ok = 1'b0;
      if (run_ok) sel_c = 3'(r);
    end
  end

  // disk and component block
  logic          nd_le1;
  logic [1:0]    disk_c;
  logic [LW-1:0] cb_c;
  logic [7:0]    rm_shift;

  assign nd_le1   = (rc_q[sel_q] <= 3'd1);
  assign rm_shift = rm_q[sel_q] >> {div_rem[1:0], 1'b0};

  always_comb begin
    if (il_zero) begin
      disk_c = rm_q[sel_q][1:0];
      cb_c   = bn_q - rs_q[sel_q];
    end else if (nd_le1) begin
      disk_c = rm_q[sel_q][1:0];
      cb_c   = {2'b00, ro_q[sel_q]} + off_q;
    end else begin
      disk_c = rm_shift[1:0];
      cb_c   = {2'b00, ro_q[sel_q]} + div_quo;
    end
  end

  // piece size
  logic [BW-1:0] whole;
  logic [LW-1:0] used_ext, sdiff;
  logic [IW-1:0] sdist;
  logic          take_all;
  logic [BW-1:0] piece, bytes_left;

  assign whole    = bytes_q >> SH;
  assign used_ext = {2'b00, used_q[disk_q]};
  assign sdiff    = (used_ext > cb_q) ? used_ext - cb_q : '0;
  assign sdist    = il_q - cboff_q;

  always_comb begin
    if (il_zero) begin
      take_all = (sdiff == '0) || (sdiff > {{(LW-BW){1'b0}}, whole});
      piece    = take_all ? bytes_q : (sdiff[BW-1:0] << SH);
    end else begin
      take_all = sdist > whole;
      piece    = take_all ? bytes_q : (sdist << SH);
    end
  end

  assign bytes_left = bytes_q - piece;

  logic [2*SW-1:0] prod;
  assign prod = cb_q[SW-1:0] * {{(SW-IW){1'b0}}, il_q};

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      il_q     <= '0;
      uni_q    <= 1'b0;
      cnt_q    <= 3'd1;
      for (int k = 0; k < NC; k++) raw_q[k] <= '0;
      total_q  <= '0;
      cfg_ok_q <= 1'b0;
      for (int r = 0; r < NR; r++) rc_q[r] <= '0;
      i_q      <= '0;
      r_q      <= '0;
      n_q      <= '0;
      fail_q   <= 1'b0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (cmd_i.op == csbm_pkg::OP_CHECK) ? chk_stop
                                                   : (cmd_i.op == csbm_pkg::OP_EMIT);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          csbm_pkg::REG_INTERLEAVE: il_q     <= cfg_data_i[IW-1:0];
          csbm_pkg::REG_UNIFORM:    uni_q    <= cfg_data_i[0];
          csbm_pkg::REG_COUNT:      cnt_q    <= cfg_data_i[2:0];
          csbm_pkg::REG_SIZE0:      raw_q[0] <= cfg_data_i;
          csbm_pkg::REG_SIZE1:      raw_q[1] <= cfg_data_i;
          csbm_pkg::REG_SIZE2:      raw_q[2] <= cfg_data_i;
          csbm_pkg::REG_SIZE3:      raw_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        csbm_pkg::OP_RB_INIT: begin
          n_q      <= n_sat;
          i_q      <= '0;
          r_q      <= '0;
          fail_q   <= (n_sat == '0);
          total_q  <= '0;
          cfg_ok_q <= 1'b0;
          for (int r = 0; r < NR; r++) rc_q[r] <= '0;
        end
        csbm_pkg::OP_TRUNC_STORE: begin
          if (trunc_s == '0) fail_q <= 1'b1;
          i_q <= i_q + 3'd1;
        end
        csbm_pkg::OP_UNIFORM: i_q <= '0;
        csbm_pkg::OP_SUM: begin
          total_q <= total_q + {2'b00, used_q[i_q[1:0]]};
          i_q     <= (i_q == 3'd3) ? '0 : i_q + 3'd1;
        end
        csbm_pkg::OP_SER_REGION: begin
          rc_q[i_q] <= 3'd1;
          i_q       <= i_q + 3'd1;
        end
        csbm_pkg::OP_FIND: found_q <= found_c;
        csbm_pkg::OP_STORE_REGION: begin
          rc_q[r_q] <= fcnt_q;
          r_q       <= r_q + 3'd1;
        end
        csbm_pkg::OP_RB_DONE: cfg_ok_q <= !fail_q;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      csbm_pkg::OP_RB_INIT: begin
        for (int k = 0; k < NC; k++) used_q[k] <= '0;
        min_q  <= '0;
        acc_q  <= '0;
        prev_q <= '0;
      end
      csbm_pkg::OP_TRUNC_STORE: begin
        used_q[i_q[1:0]] <= trunc_s;
        if (min_q == '0 || trunc_s < min_q) min_q <= trunc_s;
      end
      csbm_pkg::OP_UNIFORM: begin
        if (uni_q) begin
          for (int k = 0; k < NC; k++) if (3'(k) < n_q) used_q[k] <= min_q;
        end
      end
      csbm_pkg::OP_SER_REGION: begin
        rs_q[i_q] <= acc_q;
        ro_q[i_q] <= '0;
        rm_q[i_q] <= {6'b0, i_q[1:0]};
        acc_q     <= acc_q + {2'b00, used_q[i_q[1:0]]};
      end
      csbm_pkg::OP_FIND: begin
        small_q <= small_c;
        fcnt_q  <= fcnt_c;
        fmem_q  <= fmem_c;
      end
      csbm_pkg::OP_STORE_START: rs_q[r_q] <= div_quo;
      csbm_pkg::OP_STORE_REGION: begin
        ro_q[r_q] <= div_quo[SW-1:0];
        rm_q[r_q] <= fmem_q;
        acc_q     <= acc_q + step_scaled;
        prev_q    <= small_q;
      end
      csbm_pkg::OP_LOAD: begin
        bn_q    <= req_i.start_block;
        bytes_q <= req_i.request_bytes;
      end
      csbm_pkg::OP_CHECK: begin
        res_q.status      <= chk_code;
        res_q.disk_index  <= '0;
        res_q.disk_block  <= '0;
        res_q.piece_bytes <= '0;
        res_q.last        <= 1'b1;
      end
      csbm_pkg::OP_SEL: begin
        unit_q  <= unit_c;
        cboff_q <= il_zero ? '0 : div_rem;
        sel_q   <= sel_c;
      end
      csbm_pkg::OP_OFF: off_q <= unit_q - rs_q[sel_q];
      csbm_pkg::OP_CB: begin
        disk_q <= disk_c;
        cb_q   <= cb_c;
        blk_q  <= cb_c[SW-1:0];
      end
      csbm_pkg::OP_MUL: blk_q <= prod[SW-1:0] + {{(SW-IW){1'b0}}, cboff_q};
      csbm_pkg::OP_EMIT: begin
        res_q.status      <= csbm_pkg::STAT_PIECE;
        res_q.disk_index  <= disk_q;
        res_q.disk_block  <= blk_q;
        res_q.piece_bytes <= piece;
        res_q.last        <= (bytes_left == '0);
        bytes_q           <= bytes_left;
        bn_q              <= bn_q + {{(LW-BW){1'b0}}, piece >> SH};
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.cfg_wr     = cfg_valid_i && (cfg_index_i <= csbm_pkg::REG_SIZE3);
    stat_o.n_zero     = (n_q == '0);
    stat_o.i_eq_n     = (i_q == n_q);
    stat_o.i_eq_last  = (i_q == 3'd3);
    stat_o.trunc_zero = (trunc_s == '0);
    stat_o.il_zero    = il_zero;
    stat_o.div_done   = div_done;
    stat_o.r_full     = (r_q == 3'(NC));
    stat_o.found      = found_q;
    stat_o.chk_stop   = chk_stop;
    stat_o.nd_le1     = nd_le1;
    stat_o.emit_last  = (bytes_left == '0);
  end

  assign cfg_ready_o  = 1'b1;
  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule
`default_nettype wire

>>> rtl/csbm_ctrl.sv
// Controller FSM: sequences table rebuild and request splitting over the datapath.
// Depends on csbm_pkg.
`default_nettype none
module csbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  csbm_pkg::dp_stat_t stat_i,
  output csbm_pkg::dp_cmd_t  cmd_o
);

  csbm_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= csbm_pkg::ST_RB_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = csbm_pkg::OP_NONE;
    unique case (state_q)
      csbm_pkg::ST_RB_INIT: begin
        cmd_o.op = csbm_pkg::OP_RB_INIT;
        state_d  = csbm_pkg::ST_TRUNC;
      end
      csbm_pkg::ST_TRUNC: begin
        if (stat_i.n_zero) state_d = csbm_pkg::ST_RB_DONE;
        else if (stat_i.i_eq_n) state_d = csbm_pkg::ST_UNIFORM;
        else begin
          cmd_o.op = csbm_pkg::OP_TRUNC_DIV;
          state_d  = csbm_pkg::ST_TRUNC_WAIT;
        end
      end
      csbm_pkg::ST_TRUNC_WAIT: begin
        if (stat_i.div_done) state_d = csbm_pkg::ST_TRUNC_STORE;
      end
      csbm_pkg::ST_TRUNC_STORE: begin
        cmd_o.op = csbm_pkg::OP_TRUNC_STORE;
        state_d  = stat_i.trunc_zero ? csbm_pkg::ST_RB_DONE : csbm_pkg::ST_TRUNC;
      end
      csbm_pkg::ST_UNIFORM: begin
        cmd_o.op = csbm_pkg::OP_UNIFORM;
        state_d  = csbm_pkg::ST_SUM;
      end
      csbm_pkg::ST_SUM: begin
        cmd_o.op = csbm_pkg::OP_SUM;
        if (stat_i.i_eq_last)
          state_d = stat_i.il_zero ? csbm_pkg::ST_SER_REGION : csbm_pkg::ST_FIND;
      end
      csbm_pkg::ST_SER_REGION: begin
        if (stat_i.i_eq_n) state_d = csbm_pkg::ST_RB_DONE;
        else cmd_o.op = csbm_pkg::OP_SER_REGION;
      end
      csbm_pkg::ST_FIND: begin
        if (stat_i.r_full) state_d = csbm_pkg::ST_RB_DONE;
        else begin
          cmd_o.op = csbm_pkg::OP_FIND;
          state_d  = csbm_pkg::ST_FIND_CHK;
        end
      end
      csbm_pkg::ST_FIND_CHK: begin
        if (!stat_i.found) state_d = csbm_pkg::ST_RB_DONE;
        else begin
          cmd_o.op = csbm_pkg::OP_DIV_BN;
          state_d  = csbm_pkg::ST_WAIT_BN;
        end
      end
      csbm_pkg::ST_WAIT_BN: begin
        if (stat_i.div_done) begin
          cmd_o.op = csbm_pkg::OP_STORE_START;
          state_d  = csbm_pkg::ST_WAIT_PREV;
        end
      end
      csbm_pkg::ST_WAIT_PREV: begin
        if (stat_i.div_done) begin
          cmd_o.op = csbm_pkg::OP_STORE_REGION;
          state_d  = csbm_pkg::ST_FIND;
        end
      end
      csbm_pkg::ST_RB_DONE: begin
        cmd_o.op = csbm_pkg::OP_RB_DONE;
        state_d  = csbm_pkg::ST_IDLE;
      end
      csbm_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.op = csbm_pkg::OP_LOAD;
          state_d  = csbm_pkg::ST_CHECK;
        end
      end
      csbm_pkg::ST_CHECK: begin
        cmd_o.op = csbm_pkg::OP_CHECK;
        if (stat_i.chk_stop) state_d = csbm_pkg::ST_IDLE;
        else state_d = stat_i.il_zero ? csbm_pkg::ST_SEL : csbm_pkg::ST_DIV_UNIT;
      end
      csbm_pkg::ST_DIV_UNIT: begin
        cmd_o.op = csbm_pkg::OP_DIV_UNIT;
        state_d  = csbm_pkg::ST_WAIT_UNIT;
      end
      csbm_pkg::ST_WAIT_UNIT: begin
        if (stat_i.div_done) state_d = csbm_pkg::ST_SEL;
      end
      csbm_pkg::ST_SEL: begin
        cmd_o.op = csbm_pkg::OP_SEL;
        state_d  = stat_i.il_zero ? csbm_pkg::ST_CB : csbm_pkg::ST_OFF;
      end
      csbm_pkg::ST_OFF: begin
        cmd_o.op = csbm_pkg::OP_OFF;
        state_d  = stat_i.nd_le1 ? csbm_pkg::ST_CB : csbm_pkg::ST_DIV_ND;
      end
      csbm_pkg::ST_DIV_ND: begin
        cmd_o.op = csbm_pkg::OP_DIV_ND;
        state_d  = csbm_pkg::ST_WAIT_ND;
      end
      csbm_pkg::ST_WAIT_ND: begin
        if (stat_i.div_done) state_d = csbm_pkg::ST_CB;
      end
      csbm_pkg::ST_CB: begin
        cmd_o.op = csbm_pkg::OP_CB;
        state_d  = stat_i.il_zero ? csbm_pkg::ST_EMIT : csbm_pkg::ST_MUL;
      end
      csbm_pkg::ST_MUL: begin
        cmd_o.op = csbm_pkg::OP_MUL;
        state_d  = csbm_pkg::ST_EMIT;
      end
      csbm_pkg::ST_EMIT: begin
        cmd_o.op = csbm_pkg::OP_EMIT;
        if (stat_i.emit_last) state_d = csbm_pkg::ST_IDLE;
        else state_d = stat_i.il_zero ? csbm_pkg::ST_SEL : csbm_pkg::ST_DIV_UNIT;
      end
      default: state_d = csbm_pkg::ST_RB_INIT;
    endcase
    // a write to a defined register restarts the table rebuild
    if (stat_i.cfg_wr) state_d = csbm_pkg::ST_RB_INIT;
  end

  assign busy = (state_q != csbm_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> rtl/concat_stripe_block_mapper.sv
// Concatenated / striped block mapper: splits block requests into per-disk pieces.
// A status-only result is registered after the load and range-check states. A serial piece
// passes the select, component-block and emit states; a striped piece adds one bit-serial divide
// and a multiply, plus a second divide by disk count when the region spans several disks.
// The next item is accepted with the last result. Reset and every write to a defined register
// rebuild the table (busy high meanwhile); after reset the block is unconfigured.
`default_nettype none
module concat_stripe_block_mapper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request command port
  input  logic                         start,
  output logic                         busy,
  input  csbm_pkg::req_t               req_i,
  // result port, one item per strobe, cannot be stalled
  output logic                         res_strobe_o,
  output csbm_pkg::res_t               res_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csbm_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [csbm_pkg::CFG_W-1:0]   cfg_data_i
);

  csbm_pkg::dp_cmd_t  cmd;
  csbm_pkg::dp_stat_t stat;

  // sequencer: rebuild, range check and piece loop
  csbm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // table, request registers, shared divider and result register
  csbm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .req_i        (req_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_concat_stripe_block_mapper.sv
// Testbench for the concatenated / striped block mapper: directed and random requests
// over many disk layouts, with a scoreboard that predicts every piece. Depends on csbm_pkg.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps its own copy of the layout and queues the pieces each request yields.
class stripe_map_board;
  int unsigned        ilv, unif, ccount;
  longint unsigned    raw_sz[4];
  longint unsigned    eff_sz[4];
  longint unsigned    total;
  bit                 ready_ok;
  longint unsigned    reg_start[5];
  longint unsigned    reg_off[5];
  int unsigned        reg_cnt[5];
  int unsigned        reg_mem[5];
  csbm_pkg::res_t     pieces_due[$];
  int                 errors;
  int                 results_seen;

  function new();
    ilv = 0; unif = 0; ccount = 1;
    foreach (raw_sz[i]) raw_sz[i] = 0;
    errors = 0; results_seen = 0;
    rebuild_layout();
  endfunction

  task report(string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function void write_reg(logic [csbm_pkg::CIDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      csbm_pkg::REG_INTERLEAVE: ilv = v[15:0];
      csbm_pkg::REG_UNIFORM:    unif = v[0];
      csbm_pkg::REG_COUNT:      ccount = v[2:0];
      csbm_pkg::REG_SIZE0:      raw_sz[0] = v;
      csbm_pkg::REG_SIZE1:      raw_sz[1] = v;
      csbm_pkg::REG_SIZE2:      raw_sz[2] = v;
      csbm_pkg::REG_SIZE3:      raw_sz[3] = v;
      default: return;
    endcase
    rebuild_layout();
  endfunction

  // Truncate, equalize, then build the region table (one region per disk if serial, per distinct size if striped).
  function void rebuild_layout();
    int unsigned     n, cnt, mem;
    longint unsigned minsz, s, prev, bn, cum, smin;
    bit              found;
    ready_ok = 0; total = 0; minsz = 0;
    foreach (eff_sz[i]) eff_sz[i] = 0;
    for (int r = 0; r < 5; r++) begin
      reg_start[r] = 0; reg_off[r] = 0; reg_cnt[r] = 0; reg_mem[r] = 0;
    end
    n = (ccount > 4) ? 4 : ccount;
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      s = raw_sz[i];
      if (ilv > 1) s -= s % ilv;
      if (s == 0) begin
        foreach (eff_sz[j]) eff_sz[j] = 0;
        return;
      end
      if (minsz == 0 || s < minsz) minsz = s;
      eff_sz[i] = s;
    end
    if (unif) for (int i = 0; i < n; i++) eff_sz[i] = minsz;
    for (int i = 0; i < n; i++) total += eff_sz[i];
    if (ilv == 0) begin
      cum = 0;
      for (int i = 0; i < n; i++) begin
        reg_start[i] = cum; reg_off[i] = 0; reg_cnt[i] = 1; reg_mem[i] = i;
        cum += eff_sz[i];
      end
    end else begin
      prev = 0; bn = 0;
      for (int r = 0; r < 4; r++) begin
        smin = 0; found = 0; cnt = 0; mem = 0;
        for (int i = 0; i < n; i++)
          if (eff_sz[i] > prev && (!found || eff_sz[i] < smin)) begin
            smin = eff_sz[i]; found = 1;
          end
        if (!found) break;
        reg_start[r] = bn / ilv;
        reg_off[r] = prev / ilv;
        for (int i = 0; i < n; i++)
          if (eff_sz[i] >= smin) begin
            mem |= i << (2 * cnt);
            cnt++;
          end
        reg_cnt[r] = cnt;
        reg_mem[r] = mem & 8'hFF;
        bn += cnt * (smin - prev);
        prev = smin;
      end
    end
    ready_ok = 1;
  endfunction

  function void push_piece(logic [1:0] st, logic [1:0] dk, logic [31:0] blk,
                           logic [15:0] pb, logic lst);
    csbm_pkg::res_t e;
    e.status = st; e.disk_index = dk; e.disk_block = blk; e.piece_bytes = pb; e.last = lst;
    pieces_due.push_back(e);
  endfunction

  // Status-only result: no piece fields, always the last item of its request.
  function void push_status(logic [1:0] st);
    push_piece(st, 2'd0, 32'd0, 16'd0, 1'b1);
  endfunction

  // Note an accepted request item and queue the pieces it must produce.
  function void note_request(csbm_pkg::req_t rq);
    longint unsigned bn, bytes, nblk, unit, cboff, cb, piece, blk, off, nd;
    int unsigned     sel, disk, k;
    bn = rq.start_block; bytes = rq.request_bytes; k = 0;
    if (!ready_ok) begin
      push_status(csbm_pkg::STAT_UNCONFIG); return;
    end
    nblk = (bytes + csbm_pkg::BLOCK_BYTES - 1) / csbm_pkg::BLOCK_BYTES;
    if (bytes > csbm_pkg::MAX_REQ_BYTES) begin
      push_status(csbm_pkg::STAT_INVALID); return;
    end
    if (bn + nblk > total) begin
      if (bn == total) push_status(csbm_pkg::STAT_AT_END);
      else push_status(csbm_pkg::STAT_INVALID);
      return;
    end
    if (bytes == 0 || bn >= total) begin
      push_status(csbm_pkg::STAT_AT_END); return;
    end
    while (bytes > 0 && k < 64) begin
      unit = (ilv == 0) ? bn : bn / ilv;
      cboff = (ilv == 0) ? 0 : bn % ilv;
      sel = 0;
      for (int r = 0; r < 5; r++) begin
        if (reg_cnt[r] == 0 || reg_start[r] > unit) break;
        sel = r;
      end
      if (ilv == 0) begin
        disk = reg_mem[sel] & 3;
        cb = bn - reg_start[sel];
        piece = (eff_sz[disk] > cb) ? (eff_sz[disk] - cb) * csbm_pkg::BLOCK_BYTES : 0;
        blk = cb;
      end else begin
        off = unit - reg_start[sel];
        nd = reg_cnt[sel];
        if (nd <= 1) begin
          disk = reg_mem[sel] & 3;
          cb = reg_off[sel] + off;
        end else begin
          disk = (reg_mem[sel] >> (2 * (off % nd))) & 3;
          cb = reg_off[sel] + off / nd;
        end
        blk = cb * ilv + cboff;
        piece = (ilv - cboff) * csbm_pkg::BLOCK_BYTES;
      end
      if (piece > bytes || piece == 0) piece = bytes;
      bytes -= piece;
      push_piece(csbm_pkg::STAT_PIECE, disk[1:0], blk[31:0], piece[15:0], bytes == 0);
      k++;
      bn += piece / csbm_pkg::BLOCK_BYTES;
    end
  endfunction

  task check_result(csbm_pkg::res_t got);
    csbm_pkg::res_t e;
    results_seen++;
    if (pieces_due.size() == 0) begin
      report($sformatf("unexpected result %p", got)); return;
    end
    e = pieces_due.pop_front();
    if (got.status !== e.status || got.disk_index !== e.disk_index ||
        got.disk_block !== e.disk_block || got.piece_bytes !== e.piece_bytes ||
        got.last !== e.last)
      report($sformatf({"got st=%0d dk=%0d blk=%0h pb=%0d last=%0b, ",
                        "want st=%0d dk=%0d blk=%0h pb=%0d last=%0b"},
                       got.status, got.disk_index, got.disk_block, got.piece_bytes,
                       got.last, e.status, e.disk_index, e.disk_block, e.piece_bytes,
                       e.last));
  endtask
endclass

module tb_concat_stripe_block_mapper;

  localparam longint CYCLE_LIMIT = 20_000_000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  csbm_pkg::req_t                req_i;
  logic                          res_strobe_o;
  csbm_pkg::res_t                res_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [csbm_pkg::CIDX_W-1:0]   cfg_index_i;
  logic [csbm_pkg::CFG_W-1:0]    cfg_data_i;

  stripe_map_board     board;
  longint              cycles = 0;
  int                  requests_sent = 0;
  int                  layouts_tried = 0;
  bit                  quiet_phase = 0;

  concat_stripe_block_mapper uut (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .res_strobe_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Results cannot be held off: check each strobed item at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) board.check_result(res_o);
  end

  // Idle the sender for a random stretch: mostly short, now and then long.
  task automatic sender_gap();
    int n;
    if (quiet_phase) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  // Drive one request item; it counts once start is seen high with busy low.
  task automatic send_req(logic [csbm_pkg::LBA_W-1:0] sb,
                          logic [csbm_pkg::BYTES_W-1:0] nb);
    csbm_pkg::req_t rq;
    rq.start_block = sb; rq.request_bytes = nb;
    sender_gap();
    @(negedge clk_i);
    start = 1'b1;
    req_i = rq;
    do @(posedge clk_i); while (busy);
    board.note_request(rq);
    requests_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Wait until every expected piece has arrived, then let the pipeline drain.
  task automatic drain();
    while (board.pieces_due.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [csbm_pkg::CIDX_W-1:0] idx,
                           logic [csbm_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Load a whole layout once every expected result has arrived; later writes do not wait for busy.
  task automatic set_layout(logic [15:0] il, logic un, logic [2:0] cnt,
                            logic [31:0] s0, logic [31:0] s1,
                            logic [31:0] s2, logic [31:0] s3);
    drain();
    cfg_write(csbm_pkg::REG_INTERLEAVE, {16'h0, il});
    cfg_write(csbm_pkg::REG_UNIFORM, {31'h0, un});
    cfg_write(csbm_pkg::REG_COUNT, {29'h0, cnt});
    cfg_write(csbm_pkg::REG_SIZE0, s0);
    cfg_write(csbm_pkg::REG_SIZE1, s1);
    cfg_write(csbm_pkg::REG_SIZE2, s2);
    cfg_write(csbm_pkg::REG_SIZE3, s3);
    layouts_tried++;
  endtask

  function automatic logic [31:0] pick_size(int unsigned il);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h0;
    if (r < 20) return $urandom;
    if (r < 25) return 32'hFFFF_FFFF;
    return $urandom_range(1, 400) + ((il > 64) ? il * $urandom_range(1, 4) : 0);
  endfunction

  function automatic logic [15:0] pick_bytes();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 2048));
    if (r < 85) return 16'($urandom_range(0, 32768));
    if (r < 90) return 16'd32768;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [csbm_pkg::LBA_W-1:0] pick_start(longint unsigned tot);
    longint unsigned w;
    int unsigned     r;
    w = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
    r = $urandom_range(0, 99);
    if (tot == 0 || r < 8) return w[csbm_pkg::LBA_W-1:0];
    if (r < 14) return csbm_pkg::LBA_W'(tot);
    if (r < 24) return csbm_pkg::LBA_W'((tot > 70) ? tot - $urandom_range(0, 70) : 0);
    return csbm_pkg::LBA_W'(w % tot);
  endfunction

  initial begin
    int unsigned il;
    logic [2:0]  cnt;
    board = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: unconfigured after reset.
    send_req(34'd0, 16'd512);
    // Serial concatenation of unequal disks.
    set_layout(16'd0, 1'b0, 3'd4, 32'd10, 32'd20, 32'd5, 32'd7);
    send_req(34'd0, 16'd0);            // zero length inside the device
    send_req(34'd42, 16'd512);         // start exactly at the end
    send_req(34'd43, 16'd512);         // past the end
    send_req(34'd0, 16'd32769);        // oversized request
    send_req(34'd0, 16'd21000);        // crosses several disks, partial tail block
    send_req(34'd9, 16'd700);          // partial last block across a boundary
    send_req(34'h3_FFFF_FFFF, 16'hFFFF);
    // Striped, unequal, then uniform.
    set_layout(16'd4, 1'b0, 3'd3, 32'd18, 32'd40, 32'd9, 32'd0);
    send_req(34'd0, 16'd32768);
    send_req(34'd30, 16'd5000);
    send_req(34'd60, 16'd1);
    set_layout(16'd1, 1'b1, 3'd7, 32'd100, 32'd50, 32'd70, 32'd60);  // count saturates
    send_req(34'd13, 16'd32768);
    send_req(34'd199, 16'd512);
    // Widest interleave on the largest disks.
    set_layout(16'hFFFF, 1'b0, 3'd4, 32'hFFFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF, 32'h0001_0000);
    send_req(34'd65530, 16'd32768);
    send_req(34'h2_FFFF_0000, 16'd4096);
    // Zero-sized component and zero count leave the block unconfigured.
    set_layout(16'd8, 1'b0, 3'd2, 32'd64, 32'd7, 32'd64, 32'd64);
    send_req(34'd0, 16'd512);
    set_layout(16'd0, 1'b1, 3'd0, 32'd64, 32'd64, 32'd64, 32'd64);
    send_req(34'd0, 16'd512);

    // Random layouts, each with a burst of requests.
    while (requests_sent < 320) begin
      case ($urandom_range(0, 9))
        0, 1, 2: il = 0;
        3, 4, 5, 6: il = $urandom_range(1, 16);
        7: il = 16'hFFFF;
        default: il = $urandom_range(0, 65535);
      endcase
      cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(1, 4));
      set_layout(16'(il), 1'($urandom_range(0, 1)), cnt, pick_size(il), pick_size(il),
                 pick_size(il), pick_size(il));
      quiet_phase = ($urandom_range(0, 3) == 0);
      repeat (26) send_req(pick_start(board.total), pick_bytes());
      quiet_phase = 1'b0;
    end

    drain();
    $display("%0d requests over %0d disk layouts, %0d result items checked",
             requests_sent, layouts_tried, board.results_seen);
    if (board.errors == 0 && board.pieces_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pieces_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire
